// ===== sv/group_size_filter_relabel_macros.svh =====
// ----------------------------------------------------------------------------
// group_size_filter_relabel_macros.svh
// Assertion shorthands used by the top RTL file of the group size filter.
// ----------------------------------------------------------------------------
`ifndef GROUP_SIZE_FILTER_RELABEL_MACROS_SVH
`define GROUP_SIZE_FILTER_RELABEL_MACROS_SVH

// same-cycle implication, off while reset is high
`define GSFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define GSFR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/gsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsfr_pkg
// Widths, codes and shared types of the group size filter and relabeler.
// ----------------------------------------------------------------------------
`default_nettype none

package gsfr_pkg;

   localparam int LABEL_W    = 12;
   localparam int COUNT_W    = 17;
   localparam int ACT_W      = 2;
   localparam int LCNT_W     = 13;
   localparam int CSR_ADDR_W = 1;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [LABEL_W-1:0] LABEL_MAX = '1;

   // action codes
   localparam logic [ACT_W-1:0] ACT_COUNT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FINISH  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RELABEL = 2'd2;

   // result kinds
   localparam logic KIND_REPORT  = 1'b0;
   localparam logic KIND_RELABEL = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_MEMBERS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LABEL_COUNT = 1'b1;

   localparam logic [COUNT_W-1:0] MIN_MEMBERS_RST = 17'd1;
   localparam logic [LCNT_W-1:0]  LABEL_COUNT_RST = 13'd4096;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   typedef struct packed {
      logic               done;
      logic [LABEL_W-1:0] kept;
   } walk_status_type;

endpackage

`default_nettype wire

// ===== sv/gsfr_count_ram.sv =====
// ----------------------------------------------------------------------------
// gsfr_count_ram
// Member counter memory: one write and one registered read port, with a
// bypass of the write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfr_count_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [gsfr_pkg::COUNT_W-1:0] wr_data,
   output logic [gsfr_pkg::COUNT_W-1:0] rd_data
);
   import gsfr_pkg::*;

   logic [COUNT_W-1:0] count_mem [DEPTH];
   logic [COUNT_W-1:0] rd_q_ff;
   logic [AW-1:0]      rd_addr_ff;
   logic               fwd_valid_ff;
   logic [AW-1:0]      fwd_addr_ff;
   logic [COUNT_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff    <= count_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
   end

   // read sampled the old word when a write hit the same entry on that edge
   assign rd_data = (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : rd_q_ff;

endmodule

`default_nettype wire

// ===== sv/gsfr_map_ram.sv =====
// ----------------------------------------------------------------------------
// gsfr_map_ram
// Label map memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfr_map_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [gsfr_pkg::LABEL_W-1:0] wr_data,
   output logic [gsfr_pkg::LABEL_W-1:0] rd_data
);
   import gsfr_pkg::*;

   logic [LABEL_W-1:0] map_mem [DEPTH];
   logic [LABEL_W-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= map_mem[rd_addr];
      end
   end

   assign rd_data = rd_q_ff;

endmodule

`default_nettype wire

// ===== sv/gsfr_walker.sv =====
// ----------------------------------------------------------------------------
// gsfr_walker
// Finish sequencer: reads every counter once, clears it, and writes the
// dense new label (or zero) into the map, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfr_walker #(
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gsfr_pkg::COUNT_W-1:0]  min_members,
   input  logic [gsfr_pkg::LCNT_W-1:0]   label_count,
   input  logic [gsfr_pkg::COUNT_W-1:0]  cnt_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [gsfr_pkg::LABEL_W-1:0]  map_data,
   output gsfr_pkg::walk_status_type     status
);
   import gsfr_pkg::*;

   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   logic               issue_ff;
   logic [AW-1:0]      idx_ff;
   logic               w1_valid_ff;
   logic [AW-1:0]      w1_idx_ff;
   logic [LABEL_W-1:0] next_ff;
   logic               keep;
   logic [LABEL_W-1:0] bumped;

   assign rd_en   = issue_ff;
   assign rd_addr = idx_ff;

   always_comb begin
      keep = (w1_idx_ff != '0) && (32'(w1_idx_ff) < 32'(label_count)) &&
             (cnt_data != '0) && (cnt_data >= min_members);
      bumped   = (next_ff == LABEL_MAX) ? next_ff : next_ff + LABEL_W'(1);
      map_data = keep ? bumped : '0;
   end

   assign wr_en       = w1_valid_ff;
   assign wr_addr     = w1_idx_ff;
   assign status.done = w1_valid_ff && (w1_idx_ff == LAST_IDX);
   assign status.kept = next_ff;

   always_ff @(posedge clock) begin
      w1_idx_ff <= idx_ff;
      if (start) begin
         idx_ff <= '0;
      end else if (issue_ff) begin
         idx_ff <= idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= 1'b0;
         w1_valid_ff <= 1'b0;
         next_ff     <= '0;
      end else begin
         w1_valid_ff <= issue_ff;
         if (start) begin
            issue_ff <= 1'b1;
            next_ff  <= '0;
         end else begin
            if (issue_ff && (idx_ff == LAST_IDX)) begin
               issue_ff <= 1'b0;
            end
            if (w1_valid_ff && keep) begin
               next_ff <= bumped;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/group_size_filter_relabel.sv =====
// ----------------------------------------------------------------------------
// group_size_filter_relabel
// Counts members per group label, drops small groups on finish, gives the
// kept groups dense labels from 1, and answers old-to-new label lookups.
// ----------------------------------------------------------------------------
//
//   port group | dir | word contents
//   req_*      | in  | tuser: action; tdata: group_label
//   rsp_*      | out | tuser: result_kind; tdata: new_label, kept_groups
//   csr_*      | in  | addr: register index; data: register value
//
// Count and relabel words are taken one per cycle while no relabel word waits;
// a relabel answer leaves through the map read, held in an output register.
// A relabel word waits while the previous answer is still held downstream.
// Finish sweeps the counter memory once before the report, with req_tready
// low until the report is loaded.
// After reset the counter memory is zeroed; req_tready stays low meanwhile.
// The csr port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "group_size_filter_relabel_macros.svh"

module group_size_filter_relabel #(
   parameter int MAX_GROUPS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gsfr_pkg::REQ_DATA_W-1:0]   req_tdata,  // [11:0] group_label
   input  logic [gsfr_pkg::ACT_W-1:0]        req_tuser,  // [1:0] action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gsfr_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [11:0] new_label, [23:12] kept_groups
   output logic [0:0]                        rsp_tuser,  // [0] result_kind
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gsfr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [gsfr_pkg::COUNT_W-1:0]      csr_data
);
   import gsfr_pkg::*;

   localparam int AW = $clog2(MAX_GROUPS);
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_GROUPS - 1);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] min_members_ff;
   logic [LCNT_W-1:0]  label_count_ff;
   logic [LABEL_W-1:0] kept_total_ff;
   logic [AW-1:0]      clr_idx_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic [ACT_W-1:0]   s1_action_ff;
   logic               s1_in_range_ff;
   logic [AW-1:0]      s1_addr_ff;

   logic               out_valid_ff, out_valid_in;
   logic               out_kind_ff;
   logic [LABEL_W-1:0] out_label_ff;
   logic [LABEL_W-1:0] out_kept_ff;

   logic [ACT_W-1:0]   req_action;
   logic [LABEL_W-1:0] req_label;
   logic               req_in_range;
   logic [AW-1:0]      req_addr;
   logic               accept;
   logic               out_free;
   logic               s1_relabel, s1_finish, s1_hold;
   logic               inc_en;
   logic               load_relabel, load_report;

   logic               cnt_rd_en, cnt_wr_en;
   logic [AW-1:0]      cnt_rd_addr, cnt_wr_addr;
   logic [COUNT_W-1:0] cnt_wr_data, cnt_rd_data;
   logic               map_rd_en;
   logic [LABEL_W-1:0] map_rd_data;

   logic               walk_rd_en, walk_wr_en;
   logic [AW-1:0]      walk_rd_addr, walk_wr_addr;
   logic [LABEL_W-1:0] walk_map_data;
   walk_status_type    walk_status;

   // ---- input decode and handshake ----
   assign req_action   = req_tuser;
   assign req_label    = req_tdata[LABEL_W-1:0];
   assign req_in_range = (req_label != '0) && (32'(req_label) < 32'(label_count_ff)) &&
                         (32'(req_label) < MAX_GROUPS);
   assign req_addr     = AW'(req_label);

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_relabel = s1_valid_ff && (s1_action_ff == ACT_RELABEL);
   assign s1_finish  = s1_valid_ff && (s1_action_ff == ACT_FINISH);
   assign s1_hold    = s1_relabel && !out_free;

   assign req_tready = (state_ff == ST_RUN) && !s1_hold && !s1_finish;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign inc_en = s1_valid_ff && (s1_action_ff == ACT_COUNT) && s1_in_range_ff &&
                   (cnt_rd_data != COUNT_MAX);

   assign load_relabel = s1_relabel && out_free;
   assign load_report  = (state_ff == ST_REPORT) && out_free;
   assign s1_valid_in  = accept || s1_hold;
   assign out_valid_in = load_relabel || load_report || (out_valid_ff && !rsp_tready);

   // ---- control ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_idx_ff == LAST_IDX) state_in = ST_RUN;
         ST_RUN:    if (s1_finish) state_in = ST_WALK;
         ST_WALK:   if (walk_status.done) state_in = ST_REPORT;
         ST_REPORT: if (out_free) state_in = ST_RUN;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // counter memory write port is owned by the state
   always_comb begin
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_idx_ff;
            cnt_wr_data = '0;
         end
         ST_WALK: begin
            cnt_wr_en   = walk_wr_en;
            cnt_wr_addr = walk_wr_addr;
            cnt_wr_data = '0;
         end
         ST_RUN: begin
            cnt_wr_en   = inc_en;
            cnt_wr_addr = s1_addr_ff;
            cnt_wr_data = cnt_rd_data + COUNT_W'(1);
         end
         default: begin
            cnt_wr_en   = 1'b0;
            cnt_wr_addr = s1_addr_ff;
            cnt_wr_data = '0;
         end
      endcase
   end

   assign cnt_rd_en   = (accept && (req_action == ACT_COUNT)) || walk_rd_en;
   assign cnt_rd_addr = (state_ff == ST_WALK) ? walk_rd_addr : req_addr;
   assign map_rd_en   = accept && (req_action == ACT_RELABEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         kept_total_ff  <= '0;
         min_members_ff <= MIN_MEMBERS_RST;
         label_count_ff <= LABEL_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + AW'(1);
         end
         if (load_report) begin
            kept_total_ff <= walk_status.kept;
         end
         if (csr_valid) begin
            unique case (csr_addr)
               CSR_MIN_MEMBERS: min_members_ff <= csr_data;
               CSR_LABEL_COUNT: label_count_ff <= csr_data[LCNT_W-1:0];
               default:         min_members_ff <= min_members_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff   <= req_action;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
      end
      if (load_relabel) begin
         out_kind_ff  <= KIND_RELABEL;
         out_label_ff <= s1_in_range_ff ? map_rd_data : '0;
         out_kept_ff  <= kept_total_ff;
      end else if (load_report) begin
         out_kind_ff  <= KIND_REPORT;
         out_label_ff <= '0;
         out_kept_ff  <= walk_status.kept;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_kept_ff, out_label_ff};
   assign rsp_tuser  = out_kind_ff;

   // ---- memories and finish sequencer ----
   gsfr_count_ram #(
      .DEPTH (MAX_GROUPS),
      .AW    (AW)
   ) u_count_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_data (cnt_rd_data)
   );

   gsfr_map_ram #(
      .DEPTH (MAX_GROUPS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_addr (req_addr),
      .wr_en   (walk_wr_en),
      .wr_addr (walk_wr_addr),
      .wr_data (walk_map_data),
      .rd_data (map_rd_data)
   );

   gsfr_walker #(
      .DEPTH (MAX_GROUPS),
      .AW    (AW)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (s1_finish),
      .min_members (min_members_ff),
      .label_count (label_count_ff),
      .cnt_data    (cnt_rd_data),
      .rd_en       (walk_rd_en),
      .rd_addr     (walk_rd_addr),
      .wr_en       (walk_wr_en),
      .wr_addr     (walk_wr_addr),
      .map_data    (walk_map_data),
      .status      (walk_status)
   );

   // ---- assertions ----
   `GSFR_ASSERT_IMP(a_done_in_walk, clock, reset, walk_status.done, state_ff == ST_WALK, "walk done outside walk state")
   `GSFR_ASSERT_IMP(a_walk_owns_mem, clock, reset, walk_rd_en || walk_wr_en, state_ff == ST_WALK && !inc_en, "walker memory access outside walk")
   `GSFR_ASSERT_NXT(a_report_total, clock, reset, load_report, kept_total_ff == out_kept_ff && out_kind_ff == KIND_REPORT, "report and kept total disagree")
   `GSFR_ASSERT_IMP(a_quiet_clear, clock, reset, state_ff == ST_CLEAR, !out_valid_ff && !s1_valid_ff, "activity during clearing pass")

endmodule

`default_nettype wire

// ===== sim/gsfr_checker.sv =====
// ----------------------------------------------------------------------------
// gsfr_checker
// Watches the req, rsp and csr channels of the group size filter. Keeps its
// own copy of the member counters, the label map and both registers, works
// out the answer to every accepted finish and relabel word, and compares it
// with the rsp stream in order.
// ----------------------------------------------------------------------------
module gsfr_checker
   import gsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] group_label
   input  logic [ACT_W-1:0]      req_tuser,   // [1:0] action
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] new_label, [23:12] kept_groups
   input  logic [0:0]            rsp_tuser,   // [0] result_kind
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COUNT_W-1:0]    csr_data,
   output int                    error_count,
   output int                    pending_count
);

   localparam int GROUPS = 4096;

   typedef struct packed {
      logic               kind;
      logic [LABEL_W-1:0] new_label;
      logic [LABEL_W-1:0] kept;
   } answer_type;

   logic [COUNT_W-1:0] member_tally [GROUPS];
   logic [LABEL_W-1:0] dense_label  [GROUPS];
   logic [LABEL_W-1:0] kept_total;
   logic [COUNT_W-1:0] min_members;
   logic [LCNT_W-1:0]  label_count;
   answer_type         expected_answers [$];
   int                 mismatches = 0;

   function automatic int unsigned labels_in_use();
      return (label_count > GROUPS) ? GROUPS : int'(label_count);
   endfunction

   // finish: dense numbering of the surviving groups, then clear the tallies
   task automatic build_label_map();
      int unsigned        limit;
      logic [LABEL_W-1:0] next;
      limit = labels_in_use();
      next = '0;
      dense_label[0] = '0;
      for (int i = 1; i < GROUPS; i++) begin
         if (i < limit && member_tally[i] != '0 && member_tally[i] >= min_members) begin
            if (next != LABEL_MAX) next++;
            dense_label[i] = next;
         end else begin
            dense_label[i] = '0;
         end
      end
      for (int i = 0; i < GROUPS; i++) member_tally[i] = '0;
      kept_total = next;
   endtask

   task automatic predict_word(input logic [ACT_W-1:0] act, input logic [LABEL_W-1:0] lbl);
      answer_type  ans;
      int unsigned limit;
      limit = labels_in_use();
      case (act)
         ACT_COUNT: begin
            if (lbl != '0 && lbl < limit && member_tally[lbl] != COUNT_MAX)
               member_tally[lbl]++;
         end
         ACT_FINISH: begin
            build_label_map();
            ans.kind      = KIND_REPORT;
            ans.new_label = '0;
            ans.kept      = kept_total;
            expected_answers.push_back(ans);
         end
         ACT_RELABEL: begin
            ans.kind      = KIND_RELABEL;
            ans.new_label = (lbl != '0 && lbl < limit) ? dense_label[lbl] : '0;
            ans.kept      = kept_total;
            expected_answers.push_back(ans);
         end
         default: ;
      endcase
   endtask

   task automatic check_answer(input answer_type got);
      answer_type want;
      if (expected_answers.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: unexpected rsp word kind %0d new_label %0d kept %0d",
                     $realtime, got.kind, got.new_label, got.kept);
         mismatches++;
      end else begin
         want = expected_answers.pop_front();
         if (got.kind !== want.kind || got.new_label !== want.new_label ||
             got.kept !== want.kept) begin
            if (mismatches < 10)
               $display("%0t: rsp mismatch: expected kind %0d new_label %0d kept %0d, got kind %0d new_label %0d kept %0d",
                        $realtime, want.kind, want.new_label, want.kept,
                        got.kind, got.new_label, got.kept);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GROUPS; i++) begin
            member_tally[i] = '0;
            dense_label[i]  = '0;
         end
         kept_total  = '0;
         min_members = MIN_MEMBERS_RST;
         label_count = LABEL_COUNT_RST;
         expected_answers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_MIN_MEMBERS: min_members = csr_data;
               CSR_LABEL_COUNT: label_count = csr_data[LCNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_word(req_tuser, req_tdata[LABEL_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            check_answer({rsp_tuser[0], rsp_tdata[LABEL_W-1:0], rsp_tdata[2*LABEL_W-1:LABEL_W]});
      end
      pending_count <= expected_answers.size();
      error_count   <= mismatches;
   end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the group size filter and relabeler: a directed opening, a
// long run of kept groups, an exact threshold pass, then random rounds of
// counts, finishes and relabels under changing registers, with bursty
// sending and a stalling receiver. Checking is done by gsfr_checker.
// ----------------------------------------------------------------------------
module tb_top;

   import gsfr_pkg::*;

   localparam int RUN_LIMIT     = 3_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_WORDS  = 1450;
   localparam int SETTLE_CYCLES = 16;
   localparam int RUN_GROUPS    = 300;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;          // [11:0] group_label
   logic [ACT_W-1:0]      req_tuser  = ACT_COUNT;   // [1:0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;                // [11:0] new_label, [23:12] kept_groups
   logic [0:0]            rsp_tuser;                // [0] result_kind
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_MIN_MEMBERS;
   logic [COUNT_W-1:0]    csr_data   = '0;

   int error_count;
   int pending_count;

   int                burst_left = 0;
   bit                gaps_on    = 1'b1;
   bit                map_built  = 1'b0;
   int                hold_asked = 0;
   int                hold_done  = 0;
   int                words_sent = 0;
   logic [LCNT_W-1:0] label_count_now = LABEL_COUNT_RST;

   group_size_filter_relabel DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   gsfr_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_addr      (csr_addr),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : watchdog
      int cycle_count;
      for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // receiver: random stall modes, plus a long hold-off when asked
   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      int phase;
      mode = 0;
      mode_left = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (hold_done != hold_asked) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done++;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 256);
            end
            mode_left--;
            phase++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (phase % 4 == 0);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // one word on req; opens a new burst, after a random gap when gaps are on, when the last one ran out
   task automatic send_word(input logic [ACT_W-1:0] act, input logic [LABEL_W-1:0] lbl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = 0;
         if (gaps_on) begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 30);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            req_tuser  <= ACT_W'($urandom);
            req_tdata  <= REQ_DATA_W'(LABEL_W'($urandom));
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DATA_W'(lbl);
      do @(posedge clock); while (!req_tready);
      if (act != ACT_UNUSED) words_sent++;
      if (act == ACT_FINISH) map_built = 1'b1;
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
      // count words leave no answer; let them retire before touching registers
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input bit set_min, input logic [COUNT_W-1:0] min_value,
                            input bit set_lc, input logic [LCNT_W-1:0] lc_value);
      if (set_min) begin
         csr_valid <= 1'b1;
         csr_addr  <= CSR_MIN_MEMBERS;
         csr_data  <= min_value;
         do @(posedge clock); while (!csr_ready);
      end
      if (set_lc) begin
         csr_valid <= 1'b1;
         csr_addr  <= CSR_LABEL_COUNT;
         csr_data  <= COUNT_W'(lc_value);
         do @(posedge clock); while (!csr_ready);
         label_count_now = lc_value;
      end
      csr_valid <= 1'b0;
   endtask

   // mostly labels in use, some zero, some at the boundary, some anywhere
   function automatic logic [LABEL_W-1:0] pick_label();
      int unsigned span;
      span = (label_count_now > 4096) ? 4096 : int'(label_count_now);
      case ($urandom_range(0, 15))
         0:       return '0;
         1, 2:    return LABEL_W'($urandom_range(0, 4095));
         3:       return LABEL_W'(span - 1 + $urandom_range(0, 2));
         default: return (span > 1) ? LABEL_W'($urandom_range(1, span - 1))
                                    : LABEL_W'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic random_config();
      logic [COUNT_W-1:0] min_value;
      logic [LCNT_W-1:0]  lc_value;
      case ($urandom_range(0, 7))
         0:       min_value = '0;
         1:       min_value = 17'd65536;
         2:       min_value = COUNT_W'($urandom_range(0, 65536));
         3:       min_value = 17'd1;
         default: min_value = COUNT_W'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
         0:       lc_value = 13'd1;
         1:       lc_value = 13'd4096;
         2:       lc_value = LCNT_W'($urandom_range(1, 4096));
         default: lc_value = LCNT_W'($urandom_range(2, 48));
      endcase
      pause_until_drained();
      configure($urandom_range(0, 3) != 0, min_value, $urandom_range(0, 3) != 0, lc_value);
   endtask

   // counts then finish then lookups; a few shapes skip or repeat the finish
   task automatic random_round();
      int shape;
      int n_counts;
      int n_relabels;
      int r;
      shape = $urandom_range(0, 9);
      n_counts = (shape == 0) ? 0 : $urandom_range(5, 80);
      for (int i = 0; i < n_counts; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0) send_word(ACT_UNUSED, pick_label());
         else if (r <= 2 && map_built) send_word(ACT_RELABEL, pick_label());
         else send_word(ACT_COUNT, pick_label());
      end
      if (shape != 1) send_word(ACT_FINISH, LABEL_W'($urandom));
      if (shape == 2) send_word(ACT_FINISH, LABEL_W'($urandom));
      if (map_built) begin
         n_relabels = $urandom_range(5, 40);
         for (int i = 0; i < n_relabels; i++) begin
            if ($urandom_range(0, 19) == 0) send_word(ACT_UNUSED, pick_label());
            else send_word(ACT_RELABEL, pick_label());
         end
      end
   endtask

   initial begin : stimulus
      int round;
      int random_start;
      @(posedge clock);
      while (reset) @(posedge clock);

      // reset defaults: min 1, all labels in use
      send_word(ACT_COUNT, 12'd5);
      send_word(ACT_COUNT, 12'd5);
      send_word(ACT_COUNT, 12'd0);
      send_word(ACT_COUNT, 12'd4095);
      send_word(ACT_UNUSED, 12'd7);
      send_word(ACT_FINISH, 12'd0);
      send_word(ACT_RELABEL, 12'd0);
      send_word(ACT_RELABEL, 12'd5);
      send_word(ACT_RELABEL, 12'd4095);
      send_word(ACT_RELABEL, 12'd7);
      send_word(ACT_FINISH, 12'd4095);   // tallies were cleared: nothing kept
      send_word(ACT_RELABEL, 12'd5);

      // only label 0 exists; min 0 still drops empty groups
      pause_until_drained();
      configure(1'b1, 17'd0, 1'b1, 13'd1);
      send_word(ACT_COUNT, 12'd1);
      send_word(ACT_FINISH, 12'd0);
      send_word(ACT_RELABEL, 12'd1);

      pause_until_drained();
      configure(1'b1, 17'd3, 1'b1, 13'd10);
      repeat (3) send_word(ACT_COUNT, 12'd2);
      repeat (2) send_word(ACT_COUNT, 12'd3);
      send_word(ACT_COUNT, 12'd12);
      send_word(ACT_COUNT, 12'd9);
      send_word(ACT_FINISH, 12'd0);
      send_word(ACT_RELABEL, 12'd2);
      send_word(ACT_RELABEL, 12'd3);
      send_word(ACT_RELABEL, 12'd12);

      // a long run of kept groups, back to back
      pause_until_drained();
      configure(1'b1, 17'd1, 1'b1, 13'd4096);
      gaps_on = 1'b0;
      for (int i = 1; i <= RUN_GROUPS; i++) send_word(ACT_COUNT, LABEL_W'(i));
      send_word(ACT_FINISH, 12'd0);
      send_word(ACT_RELABEL, 12'd1);
      send_word(ACT_RELABEL, LABEL_W'(RUN_GROUPS / 2));
      send_word(ACT_RELABEL, LABEL_W'(RUN_GROUPS));
      send_word(ACT_RELABEL, LABEL_W'(RUN_GROUPS + 1));

      // exact threshold: one group above, one at, one just below the minimum
      pause_until_drained();
      configure(1'b1, 17'd40, 1'b1, 13'd4);
      repeat (41) send_word(ACT_COUNT, 12'd1);
      repeat (40) send_word(ACT_COUNT, 12'd2);
      repeat (39) send_word(ACT_COUNT, 12'd3);
      send_word(ACT_FINISH, 12'd0);
      send_word(ACT_RELABEL, 12'd1);
      send_word(ACT_RELABEL, 12'd2);
      send_word(ACT_RELABEL, 12'd3);
      send_word(ACT_RELABEL, 12'd4);

      pause_until_drained();
      configure(1'b1, 17'd1, 1'b1, 13'd24);
      random_start = words_sent;
      round = 0;
      while (words_sent - random_start < RANDOM_WORDS) begin
         round++;
         gaps_on = ($urandom_range(0, 3) != 0);
         if (round % 3 == 0) random_config();
         if (round == 6) begin
            // receiver holds off while lookups keep coming
            hold_asked++;
            for (int i = 0; i < 60; i++) send_word(ACT_RELABEL, pick_label());
         end
         random_round();
      end

      pause_until_drained();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
